// ===== rtl/core/mbe_pkg.sv =====
// mbe_pkg: shared constants and types of the mandelbrot escape-time block
// no dependencies; used by mbe_front, mbe_engine, mandelbrot_escape_time and the testbench
`timescale 1ns / 1ps

package mbe_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 28;

	// iteration counter and limit register
	localparam int          CNT_W       = 16;
	localparam logic [15:0] LIMIT_RESET = 16'd1000;

	// point queue between front and engine, power of two
	localparam int QUEUE_DEPTH = 2;

	// escape radius squared, applied as a shift of the threshold
	localparam int RADIUS_SQ_LOG2 = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} eng_state_t;

endpackage

// ===== rtl/core/mbe_front.sv =====
// mbe_front: input side; holds the limit register and queues accepted points
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_front #(
	parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mbe_pkg::CNT_W-1:0]             cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [COORD_WIDTH-1:0]         c_real,
	input  logic signed [COORD_WIDTH-1:0]         c_imag,
	input  logic                                  q_take,
	output logic                                  q_valid,
	output logic [COORD_WIDTH-1:0]                q_real,
	output logic [COORD_WIDTH-1:0]                q_imag,
	output logic [mbe_pkg::CNT_W-1:0]             q_limit
);

	localparam int DEPTH = mbe_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [mbe_pkg::CNT_W-1:0] limit_q;
	logic [mbe_pkg::CNT_W-1:0] limit_eff;
	logic [COORD_WIDTH-1:0]    real_q [DEPTH];
	logic [COORD_WIDTH-1:0]    imag_q [DEPTH];
	logic [mbe_pkg::CNT_W-1:0] lim_q  [DEPTH];
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [FILL_W-1:0]         fill_q;
	logic                      push;
	logic                      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mbe_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// a zero limit runs one iteration
	assign limit_eff = (limit_q == '0) ? mbe_pkg::CNT_W'(1) : limit_q;

	assign in_stall = (fill_q == FILL_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != '0);
	assign pop      = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			real_q[wr_ptr_q] <= c_real;
			imag_q[wr_ptr_q] <= c_imag;
			lim_q[wr_ptr_q]  <= limit_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	assign q_real  = real_q[rd_ptr_q];
	assign q_imag  = imag_q[rd_ptr_q];
	assign q_limit = lim_q[rd_ptr_q];

endmodule

// ===== rtl/core/mbe_engine.sv =====
// mbe_engine: iterates z = z*z + c on one point and drives the result register
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_engine #(
	parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_take,
	input  logic [COORD_WIDTH-1:0]    q_real,
	input  logic [COORD_WIDTH-1:0]    q_imag,
	input  logic [mbe_pkg::CNT_W-1:0] q_limit,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mbe_pkg::CNT_W-1:0] escape_count,
	output logic                      in_set
);

	localparam int PW = 2 * COORD_WIDTH;
	localparam int EW = PW + 1;
	localparam int CW = mbe_pkg::CNT_W;

	mbe_pkg::eng_state_t state_q, state_nx;

	logic signed [COORD_WIDTH-1:0] x_q, y_q, cr_q, ci_q;
	logic [CW-1:0]                 lim_q, cnt_q;
	logic signed [PW-1:0]          xx_s1, yy_s1, xy_s1;
	logic signed [PW-1:0]          x_ext, y_ext;
	logic signed [EW-1:0]          re_w, im_w, cr_ext, ci_ext;
	logic signed [EW-1:0]          re_sum, im_sum;
	logic [COORD_WIDTH-1:0]        x_new, y_new;
	logic [EW-1:0]                 mag_sq, thresh;
	logic                          esc, finish, load_out;
	logic                          res_set_q, out_valid_q, out_set_q;
	logic [CW-1:0]                 res_cnt_q, out_cnt_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mbe_pkg::ST_IDLE: if (q_valid) state_nx = mbe_pkg::ST_MUL;
			mbe_pkg::ST_MUL:  state_nx = mbe_pkg::ST_ADD;
			mbe_pkg::ST_ADD: begin
				state_nx = finish ? mbe_pkg::ST_DONE : mbe_pkg::ST_MUL;
			end
			mbe_pkg::ST_DONE: if (load_out) state_nx = mbe_pkg::ST_IDLE;
			default: state_nx = mbe_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		q_take   = (state_q == mbe_pkg::ST_IDLE) && q_valid;
		load_out = (state_q == mbe_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign x_ext = {{COORD_WIDTH{x_q[COORD_WIDTH-1]}}, x_q};
	assign y_ext = {{COORD_WIDTH{y_q[COORD_WIDTH-1]}}, y_q};

	// product registers; squares of the current z also feed the escape test
	always_ff @(posedge clk) begin
		if (state_q == mbe_pkg::ST_MUL) begin
			xx_s1 <= x_ext * x_ext;
			yy_s1 <= y_ext * y_ext;
			xy_s1 <= x_ext * y_ext;
		end
	end

	assign cr_ext = {{(EW - COORD_WIDTH){cr_q[COORD_WIDTH-1]}}, cr_q};
	assign ci_ext = {{(EW - COORD_WIDTH){ci_q[COORD_WIDTH-1]}}, ci_q};
	assign re_w   = ($signed({xx_s1[PW-1], xx_s1}) - $signed({yy_s1[PW-1], yy_s1})) >>> FRAC_BITS;
	assign im_w   = $signed({xy_s1[PW-1], xy_s1}) >>> (FRAC_BITS - 1);
	assign re_sum = re_w + cr_ext;
	assign im_sum = im_w + ci_ext;

	// clamp to the coordinate range
	always_comb begin
		if (re_sum[EW-1:COORD_WIDTH-1] == {(EW - COORD_WIDTH + 1){re_sum[EW-1]}}) begin
			x_new = re_sum[COORD_WIDTH-1:0];
		end else begin
			x_new = {re_sum[EW-1], {(COORD_WIDTH - 1){!re_sum[EW-1]}}};
		end
		if (im_sum[EW-1:COORD_WIDTH-1] == {(EW - COORD_WIDTH + 1){im_sum[EW-1]}}) begin
			y_new = im_sum[COORD_WIDTH-1:0];
		end else begin
			y_new = {im_sum[EW-1], {(COORD_WIDTH - 1){!im_sum[EW-1]}}};
		end
	end

	// squares are non-negative, so the sum is unsigned
	assign mag_sq = {1'b0, xx_s1} + {1'b0, yy_s1};
	assign thresh = EW'(1) << (2 * FRAC_BITS + mbe_pkg::RADIUS_SQ_LOG2);
	assign esc    = (cnt_q != '0) && (mag_sq > thresh);
	assign finish = esc || (cnt_q == lim_q);

	always_ff @(posedge clk) begin
		if (q_take) begin
			cr_q  <= q_real;
			ci_q  <= q_imag;
			lim_q <= q_limit;
			x_q   <= '0;
			y_q   <= '0;
			cnt_q <= '0;
		end else if (state_q == mbe_pkg::ST_ADD) begin
			if (finish) begin
				res_cnt_q <= cnt_q;
				res_set_q <= !esc;
			end else begin
				x_q   <= x_new;
				y_q   <= y_new;
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// result word register, holds while the next point runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cnt_q <= res_cnt_q;
			out_set_q <= res_set_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = out_cnt_q;
	assign in_set       = out_set_q;

endmodule

// ===== rtl/core/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit. Each input word is a point c in signed fixed point
// (COORD_WIDTH bits, FRAC_BITS fraction bits); the unit iterates z = z*z + c from
// z = 0 and returns the first iteration with |z|^2 > 4, or the limit with in_set
// high. Each iteration is a product step on the three shared multipliers (ST_MUL),
// then an update and escape-test step (ST_ADD). The engine holds one point at a
// time and takes the next only once the finished word is loaded into the result
// register, so a stalled result word holds the engine. A two-entry queue takes new
// points and the result register holds the finished word, so the input keeps
// taking points while the output stalls, until the queue fills. iteration_limit
// resets to 1000, 0 acts as 1.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
	parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mbe_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] c_real,
	input  logic signed [COORD_WIDTH-1:0] c_imag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbe_pkg::CNT_W-1:0]     escape_count,
	output logic                          in_set
);

	logic [COORD_WIDTH-1:0]        q_real, q_imag;
	logic [mbe_pkg::CNT_W-1:0]     q_limit;
	logic                          q_valid, q_take;

	mbe_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.c_real    (c_real),
		.c_imag    (c_imag),
		.q_take    (q_take),
		.q_valid   (q_valid),
		.q_real    (q_real),
		.q_imag    (q_imag),
		.q_limit   (q_limit)
	);

	mbe_engine #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_take       (q_take),
		.q_real       (q_real),
		.q_imag       (q_imag),
		.q_limit      (q_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count),
		.in_set       (in_set)
	);

	// the engine leaves idle on a take, so two takes never come back to back
	a_take_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> !q_take)
		else $error("engine took two points in consecutive cycles");

	// a take only happens when the queue holds a point
	a_take_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("engine took from an empty queue");

	// an escaped point always reports a count of at least one
	a_escape_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_set |-> escape_count != '0)
		else $error("escaped point reported with zero count");

endmodule

// ===== test/mandelbrot_escape_time_tb.sv =====
// testbench for mandelbrot_escape_time: drives Q4.28 points, predicts escape counts in a
// scoreboard class and checks each result word under random input gaps and output stalls
// depends on mbe_pkg and the mandelbrot_escape_time rtl only
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;

	localparam int W    = mbe_pkg::COORD_WIDTH_DEF;
	localparam int FRAC = mbe_pkg::FRAC_BITS_DEF;
	localparam int CW   = mbe_pkg::CNT_W;

	localparam logic signed [127:0] COORD_MAX = (128'sd1 <<< (W - 1)) - 128'sd1;
	localparam logic signed [127:0] COORD_MIN = -(128'sd1 <<< (W - 1));
	// |z|^2 > 4 in the doubled fraction scale
	localparam logic signed [127:0] ESC_LIMIT = 128'sd1 <<< (2 * FRAC + 2);

	localparam logic signed [W-1:0] C_MIN = COORD_MIN[W-1:0];
	localparam logic signed [W-1:0] C_MAX = COORD_MAX[W-1:0];

	localparam int          HOLD_CYCLES   = 2000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          DRAIN_CYCLES  = 64;
	localparam int          RANDOM_POINTS = 100;
	localparam int unsigned CYCLE_LIMIT   = 4000000;

	typedef struct packed {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
	} point_t;

	typedef struct packed {
		logic [CW-1:0] count;
		logic          in_set;
	} escape_word_t;

	class escape_scoreboard;
		escape_word_t  expected_words[$];
		logic [CW-1:0] limit;
		int            errors;
		int            points;
		int            words;
		int            in_set_words;
		int            deepest_escape;

		function new();
			limit = mbe_pkg::LIMIT_RESET;
		endfunction

		function logic signed [W-1:0] clamp_coord(logic signed [127:0] v);
			if (v > COORD_MAX)
				return C_MAX;
			if (v < COORD_MIN)
				return C_MIN;
			return v[W-1:0];
		endfunction

		function escape_word_t escape_time(logic signed [W-1:0] cr, logic signed [W-1:0] ci);
			logic signed [W-1:0] x, y;
			logic signed [127:0] re, im, mag2;
			int                  n, top;
			escape_word_t        w;
			top = (limit == 0) ? 1 : int'(limit);
			x = '0;
			y = '0;
			w.count = top[CW-1:0];
			w.in_set = 1'b1;
			for (n = 1; n <= top; n++) begin
				re = x * x - y * y;
				im = x * y;
				// 2xy / 2^F is one shift less
				re = (re >>> FRAC) + cr;
				im = (im >>> (FRAC - 1)) + ci;
				x = clamp_coord(re);
				y = clamp_coord(im);
				mag2 = x * x + y * y;
				if (mag2 > ESC_LIMIT) begin
					w.count = n[CW-1:0];
					w.in_set = 1'b0;
					break;
				end
			end
			return w;
		endfunction

		function void add_point(point_t p);
			expected_words.push_back(escape_time(p.re, p.im));
			points++;
		endfunction

		function void check_word(logic [CW-1:0] count, logic flag);
			escape_word_t exp_w;
			if (expected_words.size() == 0) begin
				$error("result word with no point outstanding: escape_count %0d in_set %0b",
					count, flag);
				errors++;
				return;
			end
			exp_w = expected_words.pop_front();
			words++;
			if (count !== exp_w.count) begin
				$error("escape_count mismatch: expected %0d, actual %0d", exp_w.count, count);
				errors++;
			end
			if (flag !== exp_w.in_set) begin
				$error("in_set mismatch: expected %0b, actual %0b", exp_w.in_set, flag);
				errors++;
			end
			if (exp_w.in_set)
				in_set_words++;
			else if (int'(exp_w.count) > deepest_escape)
				deepest_escape = int'(exp_w.count);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CW-1:0]       cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic signed [W-1:0] c_real;
	logic signed [W-1:0] c_imag;
	logic                out_valid;
	logic                out_stall;
	logic [CW-1:0]       escape_count;
	logic                in_set;

	escape_scoreboard sb = new();
	int unsigned      cycle_count = 0;
	int               limit_writes = 0;
	logic             pressure_on = 1'b0;

	mandelbrot_escape_time u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.c_real       (c_real),
		.c_imag       (c_imag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count),
		.in_set       (in_set)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_word(escape_count, in_set);
	end

	// output side: random stall modes, plus one long hold-off to back up the input
	initial begin : receiver
		int   mode, mode_left, k;
		logic held;
		mode = 0;
		mode_left = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_on && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(50, 300);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 4) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ((mode_left % 8) < 3);
				endcase
			end
		end
	end

	function automatic logic signed [W-1:0] q4_28(real r);
		return $rtoi(r * 268435456.0);
	endfunction

	function automatic point_t random_point();
		point_t p;
		int     sel, a;
		point_t anchors[8];
		anchors[0] = {q4_28(-0.75), q4_28(0.1)};
		anchors[1] = {q4_28(0.26), q4_28(0.0)};
		anchors[2] = {q4_28(-0.1), q4_28(0.65)};
		anchors[3] = {q4_28(-1.25), q4_28(0.02)};
		anchors[4] = {q4_28(0.3), q4_28(0.5)};
		anchors[5] = {q4_28(-0.5), q4_28(0.56)};
		anchors[6] = {q4_28(-1.77), q4_28(0.0)};
		anchors[7] = {q4_28(0.25), q4_28(0.0)};
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			p.re = $urandom;
			p.im = $urandom;
		end else if (sel < 45) begin
			// close to the set boundary, where escape counts get long
			a = $urandom_range(0, 7);
			p.re = anchors[a].re + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
			p.im = anchors[a].im + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
		end else begin
			// window [-2.25, 0.75] x [-1.5, 1.5]
			p.re = int'($urandom_range(0, 805306368)) - 603979776;
			p.im = int'($urandom_range(0, 805306368)) - 402653184;
		end
		return p;
	endfunction

	task automatic send_point(input point_t p);
		c_real <= p.re;
		c_imag <= p.im;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.add_point(p);
	endtask

	task automatic drive_points(input point_t pts[$]);
		int burst, gap;
		burst = $urandom_range(1, 16);
		foreach (pts[i]) begin
			send_point(pts[i]);
			burst--;
			if (burst == 0 && i != pts.size() - 1) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 16);
			end
		end
		in_valid <= 1'b0;
	endtask

	// limit changes only once every word is back and the engine has gone quiet
	task automatic set_limit(input logic [CW-1:0] value);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.limit = value;
		limit_writes++;
	endtask

	initial begin : stimulus
		point_t        pts[$];
		logic [CW-1:0] phase_limits[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		c_real = '0;
		c_imag = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: corners, boundary points and fixed cycles of the map
		pts.push_back({q4_28(0.0), q4_28(0.0)});
		pts.push_back({q4_28(-2.0), q4_28(0.0)});
		pts.push_back({q4_28(-2.0) - 32'sd1, q4_28(0.0)});
		pts.push_back({q4_28(2.0), q4_28(0.0)});
		pts.push_back({q4_28(0.0), q4_28(2.0)});
		pts.push_back({q4_28(0.0), q4_28(-2.0)});
		pts.push_back({q4_28(1.0), q4_28(0.0)});
		pts.push_back({C_MIN, q4_28(0.0)});
		pts.push_back({C_MAX, C_MAX});
		pts.push_back({C_MIN, C_MIN});
		pts.push_back({C_MIN, C_MAX});
		pts.push_back({C_MAX, C_MIN});
		pts.push_back({32'sh5555_5555, 32'shAAAA_AAAA});
		pts.push_back({q4_28(0.25), q4_28(0.0)});
		pts.push_back({q4_28(0.26), q4_28(0.0)});
		pts.push_back({q4_28(-0.75), q4_28(0.1)});
		pts.push_back({q4_28(0.0), q4_28(1.0)});
		pts.push_back({q4_28(-1.0), q4_28(0.0)});
		pts.push_back({q4_28(-0.1), q4_28(0.651)});
		drive_points(pts);

		// widest limit: one point stays in, one just outside the cusp escapes very late
		set_limit({CW{1'b1}});
		pts.delete();
		pts.push_back({q4_28(0.0), q4_28(0.0)});
		pts.push_back({q4_28(0.25) + 32'sd1, q4_28(0.0)});
		pts.push_back({q4_28(-2.0) - 32'sd1, q4_28(0.0)});
		pts.push_back({C_MAX, C_MAX});
		drive_points(pts);

		// zero limit behaves as one
		phase_limits = '{16'd0, 16'd1, 16'($urandom_range(2, 16)),
			16'($urandom_range(17, 100)), 16'd255, 16'($urandom_range(1, 400))};
		foreach (phase_limits[k]) begin
			set_limit(phase_limits[k]);
			pts.delete();
			if (k == 0)
				pts.push_back({q4_28(0.0), q4_28(0.0)});
			repeat (RANDOM_POINTS) pts.push_back(random_point());
			if (phase_limits[k] == 1)
				pressure_on = 1'b1;
			drive_points(pts);
		end

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d result words from %0d points over %0d limit settings",
			sb.words, sb.points, limit_writes + 1);
		$display("%0d points stayed in the set, latest escape at iteration %0d",
			sb.in_set_words, sb.deepest_escape);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
